@@ design/crcbm_pkg.sv @@
`default_nettype none

package crcbm_pkg;

  // CRC width and generator selection. The unused code behaves as the 32-bit mode.
  typedef enum logic [1:0] {
    MODE_CRC8  = 2'd0,
    MODE_CRC14 = 2'd1,
    MODE_CRC32 = 2'd2
  } crc_mode_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_WIDTH_MODE = 1'b0,
    CFG_INIT_VALUE = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CrcW    = 32;

  // Generator polynomials without their implicit top term.
  localparam logic [7:0]  Poly8  = 8'h2F;
  localparam logic [13:0] Poly14 = 14'h2E57;
  localparam logic [31:0] Poly32 = 32'h04C1_1DB7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } crc_in_t;

  typedef struct packed {
    logic [CrcW-1:0] remainder;
    logic            final_res;
  } crc_out_t;

endpackage

`default_nettype wire

@@ design/crc_bytewise_msb_first.sv @@
// Bytewise CRC engine, most significant bit first, non-reflected, no final XOR.
//
// Input channel: in_valid_i / in_stall_o with an in_data_i item holding one
// message byte and its first/last markers. Output channel: out_valid_o /
// out_stall_i with an out_data_o item holding the remainder after that byte
// and a flag telling whether it is the finished CRC of the message.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 selects the width (8, 14 or 32 bits), index 1 holds the init value.
// The port is always ready; registers are meant to be written while idle.
//
// A result passes from the input register through the eight-step XOR network
// into the result register; a stalled receiver can hold the item in the input
// register before it advances. One item per cycle is sustained while the
// receiver does not stall; the running remainder register closes the only
// loop, through a single eight-step network.
//
// Reset clears the pipeline, the running remainder and both registers.
// When the receiver stalls, the result register holds; the input register
// still fills once, then in_stall_o rises until the result is taken.
`default_nettype none

module crc_bytewise_msb_first
  import crcbm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire crc_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output crc_out_t                out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CrcW-1:0]    cfg_data_i
);

  crc_mode_e       mode_q;
  logic [CrcW-1:0] init_q;
  logic [CrcW-1:0] rem_q;

  logic            s1_valid_q, s1_valid_d;
  crc_in_t         s1_data_q;
  logic            out_valid_q, out_valid_d;
  crc_out_t        out_data_q;

  logic            out_take;
  logic            s1_adv;
  logic            in_acc;
  logic [CrcW-1:0] crc_next;

  assign cfg_ready_o = 1'b1;

  // The result register can load when it is empty or being drained.
  assign out_take   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_take;
  assign in_stall_o = s1_valid_q && !out_take;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  // The remainder is left-aligned in a 32-bit word so that the feedback bit
  // is always bit 31 and the byte always enters at bits 31:24. Bits below
  // the selected width stay zero because the aligned polynomial has none there.
  always_comb begin
    logic [CrcW-1:0] src;
    logic [CrcW-1:0] acc;
    logic [CrcW-1:0] poly_a;
    src = s1_data_q.first_byte ? init_q : rem_q;
    case (mode_q)
      MODE_CRC8: begin
        acc    = {src[7:0], 24'd0};
        poly_a = {Poly8, 24'd0};
      end
      MODE_CRC14: begin
        acc    = {src[13:0], 18'd0};
        poly_a = {Poly14, 18'd0};
      end
      default: begin
        acc    = src;
        poly_a = Poly32;
      end
    endcase
    acc[31:24] = acc[31:24] ^ s1_data_q.data_byte;
    for (int k = 0; k < 8; k++) begin
      if (acc[31]) begin
        acc = {acc[30:0], 1'b0} ^ poly_a;
      end else begin
        acc = {acc[30:0], 1'b0};
      end
    end
    case (mode_q)
      MODE_CRC8:  crc_next = {24'd0, acc[31:24]};
      MODE_CRC14: crc_next = {18'd0, acc[31:18]};
      default:    crc_next = acc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CRC8;
      init_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH_MODE: mode_q <= crc_mode_e'(cfg_data_i[1:0]);
        CFG_INIT_VALUE: init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        rem_q <= crc_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q.remainder <= crc_next;
      out_data_q.final_res <= s1_data_q.last_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A byte leaving the input register always shows up as a valid result.
  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced item did not reach the result register");

  // The running remainder and the presented result agree after an advance.
  a_rem_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (rem_q == out_data_o.remainder))
    else $error("running remainder differs from presented result");

  // Input stalls only while a byte is held back by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Results of the 8-bit mode carry no bits above the width.
  a_crc8_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && mode_q == MODE_CRC8) |-> (crc_next[31:8] == '0))
    else $error("8-bit remainder has upper bits set");

endmodule

`default_nettype wire
